[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define RGB2YUV_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define RGB2YUV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rgb2yuv_pkg.sv]
`timescale 1ns / 1ps

package rgb2yuv_pkg;

   // One 2x2 pixel block with its edge flags
   typedef struct packed {
      logic [23:0] pixel_top_left;
      logic [23:0] pixel_top_right;
      logic [23:0] pixel_bottom_left;
      logic [23:0] pixel_bottom_right;
      logic        has_right;
      logic        has_below;
   } req_type;

   // Four luma samples and one chroma pair
   typedef struct packed {
      logic [7:0] luma_top_left;
      logic [7:0] luma_top_right;
      logic [7:0] luma_bottom_left;
      logic [7:0] luma_bottom_right;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } rsp_type;

   // Luma weights (sum 255)
   localparam logic [7:0] LumaWeightRed   = 8'd54;
   localparam logic [7:0] LumaWeightGreen = 8'd183;
   localparam logic [7:0] LumaWeightBlue  = 8'd18;

   // Chroma weight magnitudes; signs are applied in the datapath
   localparam logic [7:0] CbWeightRed     = 8'd29;
   localparam logic [7:0] CbWeightGreen   = 8'd99;
   localparam logic [7:0] CbWeightBlue    = 8'd128;
   localparam logic [7:0] CrWeightRed     = 8'd128;
   localparam logic [7:0] CrWeightGreen   = 8'd116;
   localparam logic [7:0] CrWeightBlue    = 8'd12;

   localparam logic [7:0] ChromaOffset    = 8'd128;

endpackage

[rtl/rgb2yuv_luma.sv]
`timescale 1ns / 1ps

module rgb2yuv_luma (
   input  rgb2yuv_pkg::req_type  blk,
   output logic [3:0][7:0]       luma
);
   import rgb2yuv_pkg::*;

   logic [3:0][23:0] pix;
   logic [3:0]       present;

   assign pix[0] = blk.pixel_top_left;
   assign pix[1] = blk.pixel_top_right;
   assign pix[2] = blk.pixel_bottom_left;
   assign pix[3] = blk.pixel_bottom_right;

   assign present[0] = 1'b1;
   assign present[1] = blk.has_right;
   assign present[2] = blk.has_below;
   assign present[3] = blk.has_right & blk.has_below;

   // One weighted sum per pixel; absent pixels read as zero
   for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [15:0] wsum;
      assign wsum = {8'd0, pix[i][23:16]} * {8'd0, LumaWeightRed}
                  + {8'd0, pix[i][15:8]}  * {8'd0, LumaWeightGreen}
                  + {8'd0, pix[i][7:0]}   * {8'd0, LumaWeightBlue};
      assign luma[i] = present[i] ? wsum[15:8] : 8'd0;
   end

endmodule

[rtl/rgb2yuv_chroma.sv]
`timescale 1ns / 1ps

module rgb2yuv_chroma (
   input  rgb2yuv_pkg::req_type  blk,
   output logic [7:0]            chroma_blue,
   output logic [7:0]            chroma_red
);
   import rgb2yuv_pkg::*;

   logic [9:0]         sum_r, sum_g, sum_b;
   logic [7:0]         avg_r, avg_g, avg_b;
   logic [23:0]        px_tr, px_bl, px_br;
   logic [17:0]        cb_pos, cb_neg, cr_pos, cr_neg;
   logic signed [17:0] cb_lin, cr_lin;
   logic signed [10:0] cb_fin, cr_fin;

   // Saturate a signed result into 0..255
   function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
      logic [7:0] res;
      if (v < 0) begin
         res = 8'd0;
      end else if (v > 11'sd255) begin
         res = 8'd255;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   // Gate out the pixels that lie outside the frame
   assign px_tr = blk.has_right ? blk.pixel_top_right : 24'd0;
   assign px_bl = blk.has_below ? blk.pixel_bottom_left : 24'd0;
   assign px_br = (blk.has_right & blk.has_below) ? blk.pixel_bottom_right : 24'd0;

   // Channel sums, always divided by four
   assign sum_r = {2'd0, blk.pixel_top_left[23:16]} + {2'd0, px_tr[23:16]}
                + {2'd0, px_bl[23:16]} + {2'd0, px_br[23:16]};
   assign sum_g = {2'd0, blk.pixel_top_left[15:8]} + {2'd0, px_tr[15:8]}
                + {2'd0, px_bl[15:8]} + {2'd0, px_br[15:8]};
   assign sum_b = {2'd0, blk.pixel_top_left[7:0]} + {2'd0, px_tr[7:0]}
                + {2'd0, px_bl[7:0]} + {2'd0, px_br[7:0]};

   assign avg_r = sum_r[9:2];
   assign avg_g = sum_g[9:2];
   assign avg_b = sum_b[9:2];

   // Positive and negative partial sums, each below 2^16
   assign cb_pos = {10'd0, avg_b} * {10'd0, CbWeightBlue};
   assign cb_neg = {10'd0, avg_r} * {10'd0, CbWeightRed}
                 + {10'd0, avg_g} * {10'd0, CbWeightGreen};
   assign cr_pos = {10'd0, avg_r} * {10'd0, CrWeightRed};
   assign cr_neg = {10'd0, avg_g} * {10'd0, CrWeightGreen}
                 + {10'd0, avg_b} * {10'd0, CrWeightBlue};

   assign cb_lin = $signed(cb_pos) - $signed(cb_neg);
   assign cr_lin = $signed(cr_pos) - $signed(cr_neg);

   // Floor shift by 8, then add the offset
   assign cb_fin = $signed(cb_lin[17:8]) + $signed({3'd0, ChromaOffset});
   assign cr_fin = $signed(cr_lin[17:8]) + $signed({3'd0, ChromaOffset});

   assign chroma_blue = clamp_byte(cb_fin);
   assign chroma_red  = clamp_byte(cr_fin);

endmodule

[rtl/rgb_to_yuv420_block_core.sv]
`timescale 1ns / 1ps

// RGB to YUV 4:2:0 converter for one 2x2 pixel block per transfer
// (BT.709 weights, full range, 8-bit fixed point). Each accepted block gives
// exactly one result: four luma samples, zero for pixels outside the frame,
// and one U/V pair from the channel sums of the present pixels divided by
// four, offset by 128 and clamped. Throughput is one block per clock while
// rsp_stall is low. A block taken into the input register passes through
// the conversion logic into the result register once that register is free
// or being taken, and is offered on rsp from then on.
// req_stall rises only when both registers hold blocks and rsp_stall is high.
module rgb_to_yuv420_block_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rgb2yuv_pkg::req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rgb2yuv_pkg::rsp_type  rsp_data
);
   import rgb2yuv_pkg::*;

   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff, out_data_in;
   logic       req_take, advance;
   logic [3:0][7:0] luma;
   logic [7:0] cb, cr;

   // Handshake: input register moves on when the result register is free
   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);

   // Conversion datapath
   rgb2yuv_luma u_luma (
      .blk  (in_data_ff),
      .luma (luma)
   );

   rgb2yuv_chroma u_chroma (
      .blk         (in_data_ff),
      .chroma_blue (cb),
      .chroma_red  (cr)
   );

   always_comb begin
      out_data_in                   = out_data_ff;
      if (advance) begin
         out_data_in.luma_top_left     = luma[0];
         out_data_in.luma_top_right    = luma[1];
         out_data_in.luma_bottom_left  = luma[2];
         out_data_in.luma_bottom_right = luma[3];
         out_data_in.chroma_blue       = cb;
         out_data_in.chroma_red        = cr;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[rtl/rgb2yuv_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb2yuv_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  rgb2yuv_pkg::req_type  req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rgb2yuv_pkg::rsp_type  rsp_data
);
   import rgb2yuv_pkg::*;

   logic req_xfer;
   assign req_xfer = req_valid & ~req_stall;

   // A held result stays offered and unchanged
   `RGB2YUV_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result dropped while stalled")
   `RGB2YUV_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_data), "result changed while stalled")

   // A stalled input block stays offered and unchanged
   `RGB2YUV_ASSERT(a_req_stable, clock, reset, req_valid && req_stall |=> req_valid && $stable(req_data), "input changed while stalled")

   // Input is held back only when both stages are full and the output is blocked
   `RGB2YUV_ASSERT_ALWAYS(a_stall_cause, clock, req_stall |-> rsp_valid && rsp_stall, "input stalled with free output")

   // A fresh result follows an input transfer, with only the input register between them
   `RGB2YUV_ASSERT(a_rsp_origin, clock, reset, $rose(rsp_valid) |-> $past(req_xfer, 2), "result without input transfer")

endmodule

bind rgb_to_yuv420_block_core rgb2yuv_checker u_rgb2yuv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
